// ===== rtl/midi_record_deframer_filter_defines.svh =====
// Assertion macros used by the checker file.
`ifndef MIDI_RECORD_DEFRAMER_FILTER_DEFINES_SVH
`define MIDI_RECORD_DEFRAMER_FILTER_DEFINES_SVH

// Same-cycle implication, inactive while in reset.
`define MRDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, inactive while in reset.
`define MRDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also watches the reset itself.
`define MRDF_ASSERT_RAW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mrdf_pkg.sv =====
`timescale 1ns / 1ps

package mrdf_pkg;

    localparam int DATA_W     = 8;
    localparam int LEN_W      = 11;
    localparam int PORT_W     = 8;
    localparam int PC_W       = 4;
    localparam int MASK_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int HDR_BYTES  = 8;
    localparam int MAX_PORTS  = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam int RECORD_CAP_DEF   = 256;
    localparam int BUFFER_BYTES_DEF = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_PORT_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MASK = 1'b1;

    localparam logic [PC_W-1:0]   PORT_COUNT_RST  = 4'd1;
    localparam logic [MASK_W-1:0] FILTER_MASK_RST = 5'd0;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_PAD     = 3'b100
    } t_phase;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              drop;
        logic              last;
    } t_word;

    localparam int WORD_W = $bits(t_word);

    function automatic logic class_dropped(logic [MASK_W-1:0] mask, logic [DATA_W-1:0] s);
        logic hit;
        hit = 1'b0;
        if (s >= 8'hF8) begin
            if (s == 8'hFE) begin
                hit = mask[0];
            end else begin
                hit = (s <= 8'hF9) && mask[1];
            end
        end else begin
            case (s[7:4])
                4'hA: hit = mask[2];
                4'hD: hit = mask[3];
                4'hE: hit = mask[4];
                default: hit = 1'b0;
            endcase
        end
        return hit;
    endfunction

endpackage

// ===== rtl/mrdf_front.sv =====
`timescale 1ns / 1ps

module mrdf_front import mrdf_pkg::*; #(
    parameter int RECORD_CAP   = RECORD_CAP_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data_byte,
    input  logic [LEN_W-1:0]  i_buffer_length,
    input  logic              i_buffer_end,
    input  logic [MASK_W-1:0] i_filter_mask,
    input  logic              i_full,
    output logic              o_push,
    output t_word             o_word
);

    localparam int OFF_W  = $clog2(BUFFER_BYTES + 1);
    localparam int CNT_R  = $clog2(RECORD_CAP + 1);
    localparam int CNT_W  = (CNT_R > 2) ? CNT_R : 2;
    localparam int MAX_A  = (LEN_W > OFF_W) ? LEN_W : OFF_W;
    localparam int CMP_W  = ((MAX_A > CNT_W) ? MAX_A : CNT_W) + 1;

    t_phase             r_phase, n_phase;
    logic [OFF_W-1:0]   r_off, n_off;
    logic [2:0]         r_hidx, n_hidx;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_big, n_big;
    logic [CNT_W-1:0]   r_left, n_left;
    logic [1:0]         r_pad, n_pad;
    logic               r_drop, n_drop;
    logic               r_first, n_first;
    logic               r_stopped, n_stopped;

    logic               w_accept;
    logic [CMP_W-1:0]   w_used;
    logic [CMP_W-1:0]   w_offx;
    logic [CMP_W-1:0]   w_left;
    logic [CMP_W-1:0]   w_after;
    logic               w_active;
    logic [31:0]        w_wide;
    logic [1:0]         w_extra;
    logic [CNT_W-1:0]   w_base_cnt;
    logic               w_base_big;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;

    always_comb begin
        if (CMP_W'(i_buffer_length) > CMP_W'(BUFFER_BYTES)) begin
            w_used = CMP_W'(BUFFER_BYTES);
        end else begin
            w_used = CMP_W'(i_buffer_length);
        end
        w_offx     = CMP_W'(r_off);
        w_left     = w_used - w_offx;
        w_after    = w_left - CMP_W'(1);
        w_active   = !r_stopped && (w_offx < w_used);
        w_wide     = 32'(i_data_byte) << {r_hidx[1:0], 3'b000};
        w_extra    = 2'(2'd0 - r_cnt[1:0]);
        w_base_cnt = (r_hidx == 3'd0) ? '0 : r_cnt;
        w_base_big = (r_hidx == 3'd0) ? 1'b0 : r_big;

        n_phase   = r_phase;
        n_off     = r_off;
        n_hidx    = r_hidx;
        n_cnt     = r_cnt;
        n_big     = r_big;
        n_left    = r_left;
        n_pad     = r_pad;
        n_drop    = r_drop;
        n_first   = r_first;
        n_stopped = r_stopped;
        o_push    = 1'b0;
        o_word.data = i_data_byte;
        o_word.drop = r_drop;
        o_word.last = 1'b0;

        if (w_accept) begin
            if (w_active) begin
                case (r_phase)
                    PH_PAYLOAD: begin
                        if (r_first) begin
                            n_drop = class_dropped(i_filter_mask, i_data_byte);
                        end
                        n_first     = 1'b0;
                        n_left      = r_left - CNT_W'(1);
                        o_push      = 1'b1;
                        o_word.drop = n_drop;
                        o_word.last = (n_left == '0);
                        if (n_left == '0) begin
                            if (CMP_W'(w_extra) > w_after) begin
                                n_stopped = 1'b1;
                            end else if (w_extra == 2'd0) begin
                                n_phase = PH_HEADER;
                            end else begin
                                n_phase = PH_PAD;
                                n_pad   = w_extra;
                            end
                        end
                    end
                    PH_PAD: begin
                        if (r_pad != 2'd0) begin
                            n_pad = r_pad - 2'd1;
                        end
                        if (n_pad == 2'd0) begin
                            n_phase = PH_HEADER;
                        end
                    end
                    default: begin
                        if (r_hidx == 3'd0 && w_left < CMP_W'(HDR_BYTES)) begin
                            n_stopped = 1'b1;
                        end else begin
                            n_cnt = w_base_cnt;
                            n_big = w_base_big;
                            if (r_hidx[2]) begin
                                n_cnt = w_base_cnt | w_wide[CNT_W-1:0];
                                n_big = w_base_big | (|w_wide[31:CNT_W]);
                            end
                            if (r_hidx == 3'd7) begin
                                n_hidx = 3'd0;
                                if (n_big || n_cnt == '0 || n_cnt > CNT_W'(RECORD_CAP)
                                        || CMP_W'(n_cnt) > w_after) begin
                                    n_stopped = 1'b1;
                                end else begin
                                    n_phase = PH_PAYLOAD;
                                    n_left  = n_cnt;
                                    n_first = 1'b1;
                                end
                            end else begin
                                n_hidx = r_hidx + 3'd1;
                            end
                        end
                    end
                endcase
            end
            if (r_off < OFF_W'(BUFFER_BYTES)) begin
                n_off = r_off + OFF_W'(1);
            end
            if (i_buffer_end) begin
                n_phase   = PH_HEADER;
                n_off     = '0;
                n_hidx    = 3'd0;
                n_cnt     = '0;
                n_big     = 1'b0;
                n_left    = '0;
                n_pad     = 2'd0;
                n_drop    = 1'b0;
                n_first   = 1'b0;
                n_stopped = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_off     <= '0;
            r_hidx    <= 3'd0;
            r_cnt     <= '0;
            r_big     <= 1'b0;
            r_left    <= '0;
            r_pad     <= 2'd0;
            r_drop    <= 1'b0;
            r_first   <= 1'b0;
            r_stopped <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_off     <= n_off;
            r_hidx    <= n_hidx;
            r_cnt     <= n_cnt;
            r_big     <= n_big;
            r_left    <= n_left;
            r_pad     <= n_pad;
            r_drop    <= n_drop;
            r_first   <= n_first;
            r_stopped <= n_stopped;
        end
    end

endmodule

// ===== rtl/mrdf_fifo.sv =====
`timescale 1ns / 1ps

module mrdf_fifo import mrdf_pkg::*; #(
    parameter int WIDTH = WORD_W,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/mrdf_back.sv =====
`timescale 1ns / 1ps

module mrdf_back import mrdf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_word             i_word,
    output logic              o_pop,
    input  logic [PC_W-1:0]   i_port_count,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_payload_byte,
    output logic [PORT_W-1:0] o_port_enable,
    output logic              o_record_end
);

    logic              r_valid, n_valid;
    logic [DATA_W-1:0] r_byte;
    logic [PORT_W-1:0] r_en;
    logic              r_end;
    logic [PORT_W-1:0] w_en;

    always_comb begin
        for (int i = 0; i < PORT_W; i++) begin
            w_en[i] = (i == 0)
                   || (!i_word.drop && (PC_W'(i) < i_port_count) && (i < MAX_PORTS));
        end
    end

    assign o_pop = i_valid && (!r_valid || i_ready);

    always_comb begin
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // load the output word
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte <= i_word.data;
            r_en   <= w_en;
            r_end  <= i_word.last;
        end
    end

    assign o_valid        = r_valid;
    assign o_payload_byte = r_byte;
    assign o_port_enable  = r_en;
    assign o_record_end   = r_end;

endmodule

// ===== rtl/midi_record_deframer_filter.sv =====
`timescale 1ns / 1ps
// A payload word is written into the queue and then loaded into the output register before it shows on the output.
// Throughput: one byte per cycle, sustained while the queue is not full; the parser state updates once per byte.
// A two-entry queue sits between the parser and the output register.
// Reset (synchronous, active low) clears the parser, the queue and the output valid,
// and sets port_count to 1 and filter_mask to 0.

module midi_record_deframer_filter import mrdf_pkg::*; #(
    parameter int RECORD_CAP   = RECORD_CAP_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [DATA_W-1:0]     i_data_byte,
    input  logic [LEN_W-1:0]      i_buffer_length,
    input  logic                  i_buffer_end,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [DATA_W-1:0]     o_payload_byte,
    output logic [PORT_W-1:0]     o_port_enable,
    output logic                  o_record_end
);

    logic [PC_W-1:0]   r_port_count;
    logic [MASK_W-1:0] r_filter_mask;

    logic              w_push;
    t_word             w_push_word;
    logic              w_full;
    logic              w_pop;
    logic              w_q_valid;
    logic [WORD_W-1:0] w_q_bits;
    t_word             w_q_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_count  <= PORT_COUNT_RST;
            r_filter_mask <= FILTER_MASK_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PORT_COUNT:  r_port_count  <= i_cfg_wdata[PC_W-1:0];
                CFG_FILTER_MASK: r_filter_mask <= i_cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    mrdf_front #(
        .RECORD_CAP   (RECORD_CAP),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_buffer_length (i_buffer_length),
        .i_buffer_end    (i_buffer_end),
        .i_filter_mask   (r_filter_mask),
        .i_full          (w_full),
        .o_push          (w_push),
        .o_word          (w_push_word)
    );

    mrdf_fifo #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_word),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_bits)
    );

    assign w_q_word = t_word'(w_q_bits);

    mrdf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_q_valid),
        .i_word         (w_q_word),
        .o_pop          (w_pop),
        .i_port_count   (r_port_count),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_payload_byte (o_payload_byte),
        .o_port_enable  (o_port_enable),
        .o_record_end   (o_record_end)
    );

endmodule

// ===== rtl/mrdf_checker.sv =====
`timescale 1ns / 1ps
`include "midi_record_deframer_filter_defines.svh"

module mrdf_checker import mrdf_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [DATA_W-1:0]     o_payload_byte,
    input logic [PORT_W-1:0]     o_port_enable,
    input logic                  o_record_end
);

    `MRDF_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_payload_byte) && $stable(o_port_enable) && $stable(o_record_end), "output word changed while stalled")

    `MRDF_ASSERT_NOW(a_port0_set, o_out_valid, o_port_enable[0], "port 0 not enabled")

    `MRDF_ASSERT_NOW(a_ports_dense, o_out_valid, (o_port_enable & (o_port_enable + 8'd1)) == 8'd0, "port enable not a contiguous run from port 0")

    `MRDF_ASSERT_RAW(a_reset_idle, !i_rst_n, !o_out_valid, "output valid right after reset")

endmodule

bind midi_record_deframer_filter mrdf_checker u_checker (.*);
